// File: hdl/awlm_pkg.sv
`default_nettype none
package awlm_pkg;

  localparam int unsigned DEF_MAX_WINDOW_BLOCKS = 4096;
  localparam int unsigned DEF_MAX_METER_CELLS   = 64;

  localparam int unsigned SAMPLE_W     = 32;
  localparam int unsigned IN_TDATA_W   = 64;
  localparam int unsigned OUT_TDATA_W  = 264;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned WB_W         = 13;
  localparam int unsigned SHIFT_W      = 5;
  localparam int unsigned MW_W         = 7;
  localparam int unsigned ZC_W         = 13;
  localparam int unsigned ZS_W         = 14;
  localparam int unsigned VERDICT_W    = 2;

  localparam logic [WB_W-1:0]     RST_WINDOW_BLOCKS     = 13'd256;
  localparam logic [SHIFT_W-1:0]  RST_LEVEL_SHIFT       = 5'd16;
  localparam logic [31:0]         RST_SIGNAL_THRESHOLD  = 32'd64;
  localparam logic [31:0]         RST_SILENCE_THRESHOLD = 32'd4;
  localparam logic [31:0]         RST_METER_FULLSCALE   = 32'd256;
  localparam logic [MW_W-1:0]     RST_METER_WIDTH       = 7'd32;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_BLOCKS     = 3'd0,
    CFG_LEVEL_SHIFT       = 3'd1,
    CFG_SIGNAL_THRESHOLD  = 3'd2,
    CFG_SILENCE_THRESHOLD = 3'd3,
    CFG_METER_FULLSCALE   = 3'd4,
    CFG_METER_WIDTH       = 3'd5
  } cfg_idx_e;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_STUCK  = 2'd0,
    VERDICT_SIGNAL = 2'd1,
    VERDICT_SILENT = 2'd2,
    VERDICT_QUIET  = 2'd3
  } verdict_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SECOND,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_MAG_GO,
    ST_MAG_WAIT,
    ST_FILL_MUL,
    ST_FILL_GO,
    ST_FILL_WAIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic take;
    logic has_prev;
    logic clear;
  } acc_ctrl_t;

endpackage
`default_nettype wire

// File: hdl/awlm_accum.sv
`default_nettype none
module awlm_accum #(
  parameter int unsigned SUM_W = 46
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire awlm_pkg::acc_ctrl_t               ctrl_i,
  input  wire logic signed [awlm_pkg::SAMPLE_W-1:0] sample_i,
  output logic signed [awlm_pkg::SAMPLE_W-1:0]   min_o,
  output logic signed [awlm_pkg::SAMPLE_W-1:0]   max_o,
  output logic signed [SUM_W-1:0]                sum_o,
  output logic [SUM_W-1:0]                       mag_sum_o,
  output logic [awlm_pkg::ZC_W-1:0]              crossings_o,
  output logic [awlm_pkg::ZS_W-1:0]              zeros_o
);
  import awlm_pkg::*;

  logic signed [SAMPLE_W-1:0] min_q, min_d, max_q, max_d;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic [SUM_W-1:0]           msum_q, msum_d;
  logic [ZC_W-1:0]            zc_q, zc_d;
  logic [ZS_W-1:0]            zs_q, zs_d;
  logic                       prev_neg_q, prev_neg_d;
  logic                       neg;
  logic [SAMPLE_W:0]          mag;

  always_comb begin
    neg        = sample_i[SAMPLE_W-1];
    mag        = neg ? (33'd0 - {sample_i[SAMPLE_W-1], sample_i}) : {1'b0, sample_i};
    min_d      = min_q;
    max_d      = max_q;
    sum_d      = sum_q;
    msum_d     = msum_q;
    zc_d       = zc_q;
    zs_d       = zs_q;
    prev_neg_d = prev_neg_q;
    if (ctrl_i.clear) begin
      min_d      = SAMPLE_MAX;
      max_d      = SAMPLE_MIN;
      sum_d      = '0;
      msum_d     = '0;
      zc_d       = '0;
      zs_d       = '0;
      prev_neg_d = 1'b0;
    end else if (ctrl_i.take) begin
      if (sample_i < min_q) min_d = sample_i;
      if (sample_i > max_q) max_d = sample_i;
      sum_d  = sum_q + SUM_W'(sample_i);
      msum_d = msum_q + SUM_W'(mag);
      if (sample_i == '0) zs_d = zs_q + 1'b1;
      if (ctrl_i.has_prev && (neg != prev_neg_q)) zc_d = zc_q + 1'b1;
      prev_neg_d = neg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q      <= SAMPLE_MAX;
      max_q      <= SAMPLE_MIN;
      sum_q      <= '0;
      msum_q     <= '0;
      zc_q       <= '0;
      zs_q       <= '0;
      prev_neg_q <= 1'b0;
    end else begin
      min_q      <= min_d;
      max_q      <= max_d;
      sum_q      <= sum_d;
      msum_q     <= msum_d;
      zc_q       <= zc_d;
      zs_q       <= zs_d;
      prev_neg_q <= prev_neg_d;
    end
  end

  assign min_o       = min_q;
  assign max_o       = max_q;
  assign sum_o       = sum_q;
  assign mag_sum_o   = msum_q;
  assign crossings_o = zc_q;
  assign zeros_o     = zs_q;

endmodule
`default_nettype wire

// File: hdl/awlm_div.sv
`default_nettype none
module awlm_div #(
  parameter int unsigned DIV_W = 46
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [31:0]      divisor_i,
  output logic                  done_o,
  output logic [DIV_W-1:0]      quotient_o
);
  localparam int unsigned CNT_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]      rem_q, rem_d;
  logic [31:0]      dsr_q, dsr_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [32:0]      rem_sh;
  logic             ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh = {rem_q, quo_q[DIV_W-1]};
    ge     = rem_sh >= {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIV_W - 1);
      rem_d  = '0;
      dsr_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? 32'(rem_sh - {1'b0, dsr_q}) : rem_sh[31:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// File: hdl/audio_window_level_monitor_core.sv
// Windowed level monitor for two-sample audio blocks. Each item on the slave stream is
// one block, sample_first in tdata[31:0] and sample_second in tdata[63:32]. A block that
// does not close its window is taken with its first sample into the shared accumulator,
// then its second sample goes through the same accumulator; the next block is not taken
// before that. The block that closes a window also runs three divides on one shared
// restoring divider (mean, mean magnitude, meter fill), which is DIV_W = 46 bits wide at
// the default window limit of 4096 blocks. The finished result sits in an output register,
// so the next window's blocks are taken while it waits. Configuration writes are taken
// every cycle and must come while the block is idle.
`default_nettype none
module audio_window_level_monitor_core #(
  parameter int unsigned MAX_WINDOW_BLOCKS = awlm_pkg::DEF_MAX_WINDOW_BLOCKS,
  parameter int unsigned MAX_METER_CELLS   = awlm_pkg::DEF_MAX_METER_CELLS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // sample_first, sample_second
  input  wire logic [awlm_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // window_number, window_min, window_max, peak_to_peak, mean_value, mean_magnitude,
  // level, zero_crossings, zero_samples, verdict, meter_fill, zero pad
  output logic [awlm_pkg::OUT_TDATA_W-1:0]        m_axis_tdata_o,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [awlm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [awlm_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import awlm_pkg::*;

  localparam int unsigned BCNT_W  = $clog2(MAX_WINDOW_BLOCKS + 1);
  localparam int unsigned NSAMP_W = BCNT_W + 1;
  localparam int unsigned SUM_W   = 33 + $clog2(2 * MAX_WINDOW_BLOCKS);
  localparam int unsigned CELL_W  = $clog2(MAX_METER_CELLS + 1);
  localparam int unsigned PROD_W  = 32 + CELL_W;
  localparam int unsigned DIV_W   = (SUM_W > PROD_W) ? SUM_W : PROD_W;

  // configuration
  logic [WB_W-1:0]    wb_q;
  logic [SHIFT_W-1:0] shift_q;
  logic [31:0]        sig_th_q, sil_th_q, fullscale_q;
  logic [MW_W-1:0]    mw_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q        <= RST_WINDOW_BLOCKS;
      shift_q     <= RST_LEVEL_SHIFT;
      sig_th_q    <= RST_SIGNAL_THRESHOLD;
      sil_th_q    <= RST_SILENCE_THRESHOLD;
      fullscale_q <= RST_METER_FULLSCALE;
      mw_q        <= RST_METER_WIDTH;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WINDOW_BLOCKS:     wb_q        <= cfg_data_i[WB_W-1:0];
        CFG_LEVEL_SHIFT:       shift_q     <= cfg_data_i[SHIFT_W-1:0];
        CFG_SIGNAL_THRESHOLD:  sig_th_q    <= cfg_data_i;
        CFG_SILENCE_THRESHOLD: sil_th_q    <= cfg_data_i;
        CFG_METER_FULLSCALE:   fullscale_q <= cfg_data_i;
        CFG_METER_WIDTH:       mw_q        <= cfg_data_i[MW_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state and datapath registers
  state_e             state_q, state_d;
  logic [BCNT_W-1:0]  bcnt_q, bcnt_d;
  logic [31:0]        win_q, win_d;
  logic [31:0]        second_q;
  logic [31:0]        mean_q, mag_q;
  logic [PROD_W-1:0]  prod_q;
  logic               out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_q;

  acc_ctrl_t          acc_ctrl;
  logic signed [SAMPLE_W-1:0] acc_sample;
  logic signed [SAMPLE_W-1:0] acc_min, acc_max;
  logic signed [SUM_W-1:0]    acc_sum;
  logic [SUM_W-1:0]           acc_msum;
  logic [ZC_W-1:0]            acc_zc;
  logic [ZS_W-1:0]            acc_zs;

  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_dividend, div_quo;
  logic [31:0]        div_divisor;

  logic               accept, load_out, sel_second;
  logic [BCNT_W-1:0]  limit, bcnt_inc;
  logic [NSAMP_W-1:0] nsamp;
  logic               sum_neg;
  logic [SUM_W-1:0]   sum_abs;
  logic [31:0]        level, pp;
  logic [CELL_W-1:0]  cells;
  logic [CELL_W-1:0]  fill;
  verdict_e           verdict;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_comb begin
    if (wb_q == '0) begin
      limit = BCNT_W'(1);
    end else if (32'(wb_q) > MAX_WINDOW_BLOCKS) begin
      limit = BCNT_W'(MAX_WINDOW_BLOCKS);
    end else begin
      limit = BCNT_W'(wb_q);
    end
    if (32'(mw_q) > MAX_METER_CELLS) begin
      cells = CELL_W'(MAX_METER_CELLS);
    end else begin
      cells = CELL_W'(mw_q);
    end
  end

  assign bcnt_inc = bcnt_q + 1'b1;
  assign nsamp    = {bcnt_q, 1'b0};
  assign sum_neg  = acc_sum[SUM_W-1];
  assign sum_abs  = sum_neg ? (SUM_W'(0) - acc_sum) : acc_sum;
  assign level    = mag_q >> shift_q;
  assign pp       = 32'({acc_max[SAMPLE_W-1], acc_max} - {acc_min[SAMPLE_W-1], acc_min});

  always_comb begin
    if (pp == '0) begin
      verdict = VERDICT_STUCK;
    end else if (level >= sig_th_q) begin
      verdict = VERDICT_SIGNAL;
    end else if (level < sil_th_q) begin
      verdict = VERDICT_SILENT;
    end else begin
      verdict = VERDICT_QUIET;
    end
    if (fullscale_q == '0) begin
      fill = cells;
    end else if (div_quo > DIV_W'(cells)) begin
      fill = cells;
    end else begin
      fill = CELL_W'(div_quo);
    end
  end

  always_comb begin
    state_d      = state_q;
    bcnt_d       = bcnt_q;
    win_d        = win_q;
    acc_ctrl     = '0;
    sel_second   = 1'b0;
    div_start    = 1'b0;
    div_dividend = DIV_W'(prod_q);
    div_divisor  = fullscale_q;
    load_out     = 1'b0;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          acc_ctrl.take     = 1'b1;
          acc_ctrl.has_prev = (bcnt_q != '0);
          state_d           = ST_SECOND;
        end
      end
      ST_SECOND: begin
        sel_second        = 1'b1;
        acc_ctrl.take     = 1'b1;
        acc_ctrl.has_prev = 1'b1;
        bcnt_d            = bcnt_inc;
        state_d           = (bcnt_inc >= limit) ? ST_MEAN_GO : ST_IDLE;
      end
      ST_MEAN_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(sum_abs);
        div_divisor  = 32'(nsamp);
        state_d      = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (div_done) state_d = ST_MAG_GO;
      end
      ST_MAG_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(acc_msum);
        div_divisor  = 32'(nsamp);
        state_d      = ST_MAG_WAIT;
      end
      ST_MAG_WAIT: begin
        if (div_done) state_d = ST_FILL_MUL;
      end
      ST_FILL_MUL: begin
        state_d = ST_FILL_GO;
      end
      ST_FILL_GO: begin
        div_start = 1'b1;
        state_d   = ST_FILL_WAIT;
      end
      ST_FILL_WAIT: begin
        if (div_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          load_out       = 1'b1;
          out_valid_d    = 1'b1;
          acc_ctrl.clear = 1'b1;
          bcnt_d         = '0;
          win_d          = win_q + 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign acc_sample = sel_second ? $signed(second_q) : $signed(s_axis_tdata_i[31:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bcnt_q      <= '0;
      win_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bcnt_q      <= bcnt_d;
      win_q       <= win_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) second_q <= s_axis_tdata_i[63:32];
    if (state_q == ST_MEAN_WAIT && div_done) begin
      mean_q <= sum_neg ? (32'd0 - div_quo[31:0]) : div_quo[31:0];
    end
    if (state_q == ST_MAG_WAIT && div_done) mag_q <= div_quo[31:0];
    if (state_q == ST_FILL_MUL) prod_q <= PROD_W'(level) * PROD_W'(cells);
    if (load_out) begin
      out_q <= {4'd0, 7'(fill), verdict, acc_zs, acc_zc, level, mag_q, mean_q, pp,
                acc_max, acc_min, win_q};
    end
  end

  assign m_axis_tdata_o  = out_q;
  assign m_axis_tvalid_o = out_valid_q;

  awlm_accum #(
    .SUM_W (SUM_W)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (acc_ctrl),
    .sample_i    (acc_sample),
    .min_o       (acc_min),
    .max_o       (acc_max),
    .sum_o       (acc_sum),
    .mag_sum_o   (acc_msum),
    .crossings_o (acc_zc),
    .zeros_o     (acc_zs)
  );

  awlm_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

endmodule
`default_nettype wire

// File: hdl/awlm_checker.sv
`default_nettype none
module awlm_checker (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic [awlm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  input  wire logic                               m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  input  wire logic                               cfg_valid_i,
  input  wire logic                               cfg_ready_o
);
  import awlm_pkg::*;

  logic signed [31:0] w_min, w_max;
  logic [31:0]        w_pp, w_mag, w_level;
  logic [1:0]         w_verdict;

  assign w_min     = $signed(m_axis_tdata_o[63:32]);
  assign w_max     = $signed(m_axis_tdata_o[95:64]);
  assign w_pp      = m_axis_tdata_o[127:96];
  assign w_mag     = m_axis_tdata_o[191:160];
  assign w_level   = m_axis_tdata_o[223:192];
  assign w_verdict = m_axis_tdata_o[252:251];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (w_max >= w_min) && (w_pp == 32'(w_max - w_min)))
    else $error("min, max and peak to peak disagree");

  a_stuck: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((w_pp == '0) == (w_verdict == VERDICT_STUCK)))
    else $error("stuck verdict does not match peak to peak");

  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (w_level <= w_mag))
    else $error("level above mean magnitude");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

endmodule

bind audio_window_level_monitor_core awlm_checker u_awlm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .cfg_valid_i     (cfg_valid_i),
  .cfg_ready_o     (cfg_ready_o)
);
`default_nettype wire
